/* rtl/core/lctv_pkg.sv */
// Package with constants, types, the sine table and helper functions of the velocity controller.
package lctv_pkg;

   localparam int FRAC_BITS = 16;
   localparam int SINE_TABLE_BITS = 10;

   localparam int REG_W = 21;
   localparam int POS_W = 32;
   localparam int HEAD_W = 19;
   localparam int PHASE_W = 16;
   localparam int VEL_W = 22;
   localparam int FLAG_W = 4;
   localparam int NUM_REGS = 8;
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   localparam int SIN_W = FRAC_BITS + 2;
   localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
   localparam int REFP_W = REG_W + 3;
   localparam int WC_W = REG_W + 2;
   localparam int D_W = 2 * REG_W + 3 - FRAC_BITS;
   localparam int U_W = REG_W + POS_W + 3 - FRAC_BITS;
   localparam int V_W = U_W + 2;
   localparam int HSHIFT = 32 + FRAC_BITS - SINE_TABLE_BITS;
   localparam int HPROD_W = HEAD_W + 31;
   localparam int HP_W = FRAC_BITS + 2;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [30:0] INV_TWO_PI_Q32 = 31'd683565276;
   localparam logic [63:0] HALF_PI_L =
      (HALF_PI_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
   localparam logic signed [HP_W-1:0] HALF_PI = HP_W'(HALF_PI_L);
   localparam logic signed [REFP_W-1:0] Y_OFF = -(REFP_W'(1) << (FRAC_BITS - 1));
   localparam logic signed [REFP_W-1:0] Z_OFF = REFP_W'(3) << (FRAC_BITS - 1);

   typedef enum logic [2:0] {
      REG_GAIN_K,
      REG_LIMIT_XY,
      REG_LIMIT_Z,
      REG_LIMIT_YAW_RATE,
      REG_OMEGA,
      REG_AMP_X,
      REG_AMP_Y,
      REG_AMP_Z
   } reg_idx_type;

   typedef struct packed {
      logic [REG_W-1:0] gain_k;
      logic [REG_W-1:0] limit_xy;
      logic [REG_W-1:0] limit_z;
      logic [REG_W-1:0] limit_yaw_rate;
      logic [REG_W-1:0] omega;
      logic [REG_W-1:0] amp_x;
      logic [REG_W-1:0] amp_y;
      logic [REG_W-1:0] amp_z;
   } cfg_type;

   localparam logic [REG_W-1:0] RST_GAIN_K = 21'd6554;
   localparam logic [REG_W-1:0] RST_LIMIT_XY = 21'd65536;
   localparam logic [REG_W-1:0] RST_LIMIT_Z = 21'd65536;
   localparam logic [REG_W-1:0] RST_LIMIT_YAW_RATE = 21'd262144;
   localparam logic [REG_W-1:0] RST_OMEGA = 21'd4118;
   localparam logic [REG_W-1:0] RST_AMP_X = 21'd196608;
   localparam logic [REG_W-1:0] RST_AMP_Y = 21'd98304;
   localparam logic [REG_W-1:0] RST_AMP_Z = 21'd32768;

   typedef logic [FRAC_BITS:0] qtab_type [QUARTER+1];

   // First quadrant of the sine from a Taylor series in Q30, rounded to the output format.
   function automatic qtab_type build_qtab();
      qtab_type t;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint sum;
      for (int q = 0; q <= QUARTER; q++) begin
         x = (64'(q) * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2);
         x2 = (x * x) >> 30;
         term = x;
         sum = longint'(x);
         term = ((term * x2) >> 30) / 64'd6;
         sum = sum - longint'(term);
         term = ((term * x2) >> 30) / 64'd20;
         sum = sum + longint'(term);
         term = ((term * x2) >> 30) / 64'd42;
         sum = sum - longint'(term);
         term = ((term * x2) >> 30) / 64'd72;
         sum = sum + longint'(term);
         term = ((term * x2) >> 30) / 64'd110;
         sum = sum - longint'(term);
         term = ((term * x2) >> 30) / 64'd156;
         sum = sum + longint'(term);
         if (sum < 0) begin
            sum = 0;
         end
         sum = (sum + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
         t[q] = (FRAC_BITS + 1)'(sum);
      end
      return t;
   endfunction

   localparam qtab_type QTAB = build_qtab();

   function automatic logic signed [SIN_W-1:0] table_sin(input logic [SINE_TABLE_BITS-1:0] i);
      logic [1:0] quad;
      logic [SINE_TABLE_BITS-3:0] r;
      logic [SINE_TABLE_BITS-2:0] a;
      logic signed [SIN_W-1:0] mag;
      quad = i[SINE_TABLE_BITS-1:SINE_TABLE_BITS-2];
      r = i[SINE_TABLE_BITS-3:0];
      a = quad[0] ? ((SINE_TABLE_BITS - 1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
      mag = $signed({1'b0, QTAB[a]});
      return quad[1] ? -mag : mag;
   endfunction

   function automatic logic signed [POS_W-1:0] sat_err(input logic signed [POS_W:0] v);
      logic signed [POS_W-1:0] res;
      if (v[POS_W] != v[POS_W-1]) begin
         res = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
         res = v[POS_W-1:0];
      end
      return res;
   endfunction

endpackage

/* rtl/core/lctv_if.sv */
// Item channel interfaces for the measurement input and the velocity command output.
interface lctv_req_if
   import lctv_pkg::*;
   ();
   logic valid;
   logic ready;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic signed [POS_W-1:0] pos_z;
   logic signed [HEAD_W-1:0] heading;
   logic [PHASE_W-1:0] phase;

   modport source (output valid, pos_x, pos_y, pos_z, heading, phase, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, heading, phase, output ready);
endinterface

interface lctv_rsp_if
   import lctv_pkg::*;
   ();
   logic valid;
   logic ready;
   logic signed [VEL_W-1:0] vel_x;
   logic signed [VEL_W-1:0] vel_y;
   logic signed [VEL_W-1:0] vel_z;
   logic signed [VEL_W-1:0] yaw_rate;
   logic [FLAG_W-1:0] sat_flags;
   logic signed [POS_W-1:0] err_x;
   logic signed [POS_W-1:0] err_y;
   logic signed [POS_W-1:0] err_z;
   logic signed [POS_W-1:0] err_heading;
   logic signed [POS_W-1:0] ref_x;
   logic signed [POS_W-1:0] ref_y;
   logic signed [POS_W-1:0] ref_z;

   modport source (output valid, vel_x, vel_y, vel_z, yaw_rate, sat_flags, err_x, err_y,
                   err_z, err_heading, ref_x, ref_y, ref_z, input ready);
   modport sink (input valid, vel_x, vel_y, vel_z, yaw_rate, sat_flags, err_x, err_y,
                 err_z, err_heading, ref_x, ref_y, ref_z, output ready);
endinterface

/* rtl/core/lctv_csr.sv */
// Configuration register file with an APB-style write and read port.
module lctv_csr
   import lctv_pkg::*;
   (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
   );

   cfg_type cfg_ff;
   reg_idx_type idx;
   logic [REG_W-1:0] wdata;
   logic [REG_W-1:0] rdata;

   assign idx = reg_idx_type'(paddr[ADDR_W-1:2]);
   assign wdata = pwdata[REG_W-1:0];
   assign pready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_k <= RST_GAIN_K;
         cfg_ff.limit_xy <= RST_LIMIT_XY;
         cfg_ff.limit_z <= RST_LIMIT_Z;
         cfg_ff.limit_yaw_rate <= RST_LIMIT_YAW_RATE;
         cfg_ff.omega <= RST_OMEGA;
         cfg_ff.amp_x <= RST_AMP_X;
         cfg_ff.amp_y <= RST_AMP_Y;
         cfg_ff.amp_z <= RST_AMP_Z;
      end else if (psel && penable && pwrite) begin
         case (idx)
            REG_GAIN_K: cfg_ff.gain_k <= wdata;
            REG_LIMIT_XY: cfg_ff.limit_xy <= wdata;
            REG_LIMIT_Z: cfg_ff.limit_z <= wdata;
            REG_LIMIT_YAW_RATE: cfg_ff.limit_yaw_rate <= wdata;
            REG_OMEGA: cfg_ff.omega <= wdata;
            REG_AMP_X: cfg_ff.amp_x <= wdata;
            REG_AMP_Y: cfg_ff.amp_y <= wdata;
            REG_AMP_Z: cfg_ff.amp_z <= wdata;
            default: cfg_ff.gain_k <= cfg_ff.gain_k;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_GAIN_K: rdata = cfg_ff.gain_k;
         REG_LIMIT_XY: rdata = cfg_ff.limit_xy;
         REG_LIMIT_Z: rdata = cfg_ff.limit_z;
         REG_LIMIT_YAW_RATE: rdata = cfg_ff.limit_yaw_rate;
         REG_OMEGA: rdata = cfg_ff.omega;
         REG_AMP_X: rdata = cfg_ff.amp_x;
         REG_AMP_Y: rdata = cfg_ff.amp_y;
         REG_AMP_Z: rdata = cfg_ff.amp_z;
         default: rdata = '0;
      endcase
   end

   assign prdata = DATA_W'(rdata);

endmodule

/* rtl/core/lctv_sine.sv */
// Sine and cosine lookup for one table index, served by the quarter-wave table.
module lctv_sine
   import lctv_pkg::*;
   (
   input  logic [SINE_TABLE_BITS-1:0]  idx,
   output logic signed [SIN_W-1:0]     sin_val,
   output logic signed [SIN_W-1:0]     cos_val
   );

   logic [SINE_TABLE_BITS-1:0] cos_idx;

   assign cos_idx = idx + SINE_TABLE_BITS'(QUARTER);
   assign sin_val = table_sin(idx);
   assign cos_val = table_sin(cos_idx);

endmodule

/* rtl/core/lemniscate_tracking_velocity_ctrl.sv */
// Top level of the lemniscate trajectory tracking velocity controller pipeline.
//
// The req channel carries one control tick per item: measured position, yaw and the
// trajectory phase. The rsp channel returns one item per tick with the saturated body
// frame velocity commands, saturation flags, tracking errors and the reference position.
// Both channels use valid and ready; an item moves when both are high.
// The APB-style port sets gains, limits, frequency and amplitudes; write it only while
// no item is in flight. Reads return the stored register values.
// The pipeline has seven register stages: table index, table lookup, reference products,
// derivatives and errors, gain products, body rotation, and saturation into the output
// register. A new item can be taken every cycle as long as the receiver does not stall.
// When the receiver stalls, the output register holds its item and the stages behind it
// fill their empty slots before ready drops. Reset clears every valid bit and loads the
// register defaults.
module lemniscate_tracking_velocity_ctrl
   import lctv_pkg::*;
   (
   input  logic              clock,
   input  logic              reset,
   lctv_req_if.sink          req,
   lctv_rsp_if.source        rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
   );

   localparam int NSTG = 7;
   localparam logic signed [U_W+SIN_W:0] RND_R = (U_W + SIN_W + 1)'(1) << (FRAC_BITS - 1);

   cfg_type cfg;
   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] en;

   lctv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   always_comb begin
      en[NSTG-1] = !v_ff[NSTG-1] || rsp.ready;
      for (int i = NSTG - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign req.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req.valid;
         end
         for (int i = 1; i < NSTG; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // Stage 0: table indices.
   logic [SINE_TABLE_BITS-1:0] i1_in, i2_in, ih_in;
   logic signed [HPROD_W-1:0] hprod;
   logic [SINE_TABLE_BITS-1:0] s0_i1_ff, s0_i2_ff, s0_ih_ff;
   logic signed [POS_W-1:0] s0_px_ff, s0_py_ff, s0_pz_ff;
   logic signed [HEAD_W-1:0] s0_hd_ff;

   assign i1_in = req.phase[PHASE_W-1:PHASE_W-SINE_TABLE_BITS];
   assign i2_in = req.phase[PHASE_W-2:PHASE_W-1-SINE_TABLE_BITS];
   assign hprod = HPROD_W'(req.heading * $signed({1'b0, INV_TWO_PI_Q32}))
                  + (HPROD_W'(1) << (HSHIFT - 1));
   assign ih_in = hprod[HSHIFT+SINE_TABLE_BITS-1:HSHIFT];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_i1_ff <= i1_in;
         s0_i2_ff <= i2_in;
         s0_ih_ff <= ih_in;
         s0_px_ff <= req.pos_x;
         s0_py_ff <= req.pos_y;
         s0_pz_ff <= req.pos_z;
         s0_hd_ff <= req.heading;
      end
   end

   // Stage 1: sine and cosine lookups.
   logic signed [SIN_W-1:0] s_in, c_in, s2_in, c2_in, sh_in, ch_in;
   logic signed [SIN_W-1:0] s1_s_ff, s1_c_ff, s1_s2_ff, s1_c2_ff, s1_sh_ff, s1_ch_ff;
   logic signed [POS_W-1:0] s1_px_ff, s1_py_ff, s1_pz_ff;
   logic signed [HEAD_W-1:0] s1_hd_ff;

   lctv_sine u_sine_phase  (.idx(s0_i1_ff), .sin_val(s_in),  .cos_val(c_in));
   lctv_sine u_sine_phase2 (.idx(s0_i2_ff), .sin_val(s2_in), .cos_val(c2_in));
   lctv_sine u_sine_head   (.idx(s0_ih_ff), .sin_val(sh_in), .cos_val(ch_in));

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_s_ff <= s_in;
         s1_c_ff <= c_in;
         s1_s2_ff <= s2_in;
         s1_c2_ff <= c2_in;
         s1_sh_ff <= sh_in;
         s1_ch_ff <= ch_in;
         s1_px_ff <= s0_px_ff;
         s1_py_ff <= s0_py_ff;
         s1_pz_ff <= s0_pz_ff;
         s1_hd_ff <= s0_hd_ff;
      end
   end

   // Stage 2: reference position and omega products.
   localparam int P2_W = REG_W + 1 + SIN_W;
   localparam logic signed [P2_W-1:0] RND2 = P2_W'(1) << (FRAC_BITS - 1);
   logic signed [P2_W-1:0] p_rx, p_ry, p_rz, p_ryaw, p_wc, p_wc2;
   logic signed [REFP_W-1:0] rx_in, ry_in, rz_in, ryaw_in;
   logic signed [WC_W-1:0] wc_in, wc2_in;
   logic signed [REFP_W-1:0] s2_rx_ff, s2_ry_ff, s2_rz_ff, s2_ryaw_ff;
   logic signed [WC_W-1:0] s2_wc_ff, s2_wc2_ff;
   logic signed [SIN_W-1:0] s2_sh_ff, s2_ch_ff;
   logic signed [POS_W-1:0] s2_px_ff, s2_py_ff, s2_pz_ff;
   logic signed [HEAD_W-1:0] s2_hd_ff;

   assign p_rx = $signed({1'b0, cfg.amp_x}) * s1_s_ff + RND2;
   assign p_ry = $signed({1'b0, cfg.amp_y}) * s1_s2_ff + RND2;
   assign p_rz = $signed({1'b0, cfg.amp_z}) * s1_s_ff + RND2;
   assign p_ryaw = P2_W'(HALF_PI * s1_s_ff) + RND2;
   assign p_wc = $signed({1'b0, cfg.omega}) * s1_c_ff + RND2;
   assign p_wc2 = $signed({1'b0, cfg.omega}) * s1_c2_ff + RND2;
   assign rx_in = REFP_W'(p_rx >>> FRAC_BITS);
   assign ry_in = Y_OFF + REFP_W'(p_ry >>> FRAC_BITS);
   assign rz_in = Z_OFF + REFP_W'(p_rz >>> FRAC_BITS);
   assign ryaw_in = REFP_W'(p_ryaw >>> FRAC_BITS);
   assign wc_in = WC_W'(p_wc >>> FRAC_BITS);
   assign wc2_in = WC_W'(p_wc2 >>> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_rx_ff <= rx_in;
         s2_ry_ff <= ry_in;
         s2_rz_ff <= rz_in;
         s2_ryaw_ff <= ryaw_in;
         s2_wc_ff <= wc_in;
         s2_wc2_ff <= wc2_in;
         s2_sh_ff <= s1_sh_ff;
         s2_ch_ff <= s1_ch_ff;
         s2_px_ff <= s1_px_ff;
         s2_py_ff <= s1_py_ff;
         s2_pz_ff <= s1_pz_ff;
         s2_hd_ff <= s1_hd_ff;
      end
   end

   // Stage 3: feedforward derivatives and tracking errors.
   localparam int P3_W = REG_W + 1 + WC_W;
   localparam logic signed [P3_W-1:0] RND3 = P3_W'(1) << (FRAC_BITS - 1);
   logic signed [P3_W-1:0] p_dx, p_dy, p_dz, p_dyaw;
   logic signed [D_W-1:0] dx_in, dy_in, dz_in, dyaw_in;
   logic signed [POS_W-1:0] ex_in, ey_in, ez_in, eh_in;
   logic signed [D_W-1:0] s3_dx_ff, s3_dy_ff, s3_dz_ff, s3_dyaw_ff;
   logic signed [POS_W-1:0] s3_ex_ff, s3_ey_ff, s3_ez_ff, s3_eh_ff;
   logic signed [REFP_W-1:0] s3_rx_ff, s3_ry_ff, s3_rz_ff;
   logic signed [SIN_W-1:0] s3_sh_ff, s3_ch_ff;

   assign p_dx = $signed({1'b0, cfg.amp_x}) * s2_wc_ff + RND3;
   assign p_dy = $signed({1'b0, cfg.amp_y}) * s2_wc2_ff + RND3;
   assign p_dz = $signed({1'b0, cfg.amp_z}) * s2_wc_ff + RND3;
   assign p_dyaw = P3_W'(HALF_PI * s2_wc_ff) + RND3;
   assign dx_in = D_W'(p_dx >>> FRAC_BITS);
   assign dy_in = D_W'(p_dy >>> FRAC_BITS) <<< 1;
   assign dz_in = D_W'(p_dz >>> FRAC_BITS);
   assign dyaw_in = D_W'(p_dyaw >>> FRAC_BITS);
   assign ex_in = sat_err((POS_W + 1)'(s2_px_ff) - (POS_W + 1)'(s2_rx_ff));
   assign ey_in = sat_err((POS_W + 1)'(s2_py_ff) - (POS_W + 1)'(s2_ry_ff));
   assign ez_in = sat_err((POS_W + 1)'(s2_pz_ff) - (POS_W + 1)'(s2_rz_ff));
   assign eh_in = sat_err((POS_W + 1)'(s2_hd_ff) - (POS_W + 1)'(s2_ryaw_ff));

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_dx_ff <= dx_in;
         s3_dy_ff <= dy_in;
         s3_dz_ff <= dz_in;
         s3_dyaw_ff <= dyaw_in;
         s3_ex_ff <= ex_in;
         s3_ey_ff <= ey_in;
         s3_ez_ff <= ez_in;
         s3_eh_ff <= eh_in;
         s3_rx_ff <= s2_rx_ff;
         s3_ry_ff <= s2_ry_ff;
         s3_rz_ff <= s2_rz_ff;
         s3_sh_ff <= s2_sh_ff;
         s3_ch_ff <= s2_ch_ff;
      end
   end

   // Stage 4: gain products and commands.
   localparam int P4_W = REG_W + 1 + POS_W;
   localparam logic signed [P4_W-1:0] RND4 = P4_W'(1) << (FRAC_BITS - 1);
   logic signed [P4_W-1:0] p_kx, p_ky, p_kz, p_kh;
   logic signed [U_W-1:0] ux_in, uy_in, vz_in, wz_in;
   logic signed [U_W-1:0] s4_ux_ff, s4_uy_ff, s4_vz_ff, s4_wz_ff;
   logic signed [POS_W-1:0] s4_ex_ff, s4_ey_ff, s4_ez_ff, s4_eh_ff;
   logic signed [REFP_W-1:0] s4_rx_ff, s4_ry_ff, s4_rz_ff;
   logic signed [SIN_W-1:0] s4_sh_ff, s4_ch_ff;

   assign p_kx = $signed({1'b0, cfg.gain_k}) * s3_ex_ff + RND4;
   assign p_ky = $signed({1'b0, cfg.gain_k}) * s3_ey_ff + RND4;
   assign p_kz = $signed({1'b0, cfg.gain_k}) * s3_ez_ff + RND4;
   assign p_kh = $signed({1'b0, cfg.gain_k}) * s3_eh_ff + RND4;
   assign ux_in = U_W'(s3_dx_ff) - U_W'(p_kx >>> FRAC_BITS);
   assign uy_in = U_W'(s3_dy_ff) - U_W'(p_ky >>> FRAC_BITS);
   assign vz_in = U_W'(s3_dz_ff) - U_W'(p_kz >>> FRAC_BITS);
   assign wz_in = U_W'(s3_dyaw_ff) - U_W'(p_kh >>> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_ux_ff <= ux_in;
         s4_uy_ff <= uy_in;
         s4_vz_ff <= vz_in;
         s4_wz_ff <= wz_in;
         s4_ex_ff <= s3_ex_ff;
         s4_ey_ff <= s3_ey_ff;
         s4_ez_ff <= s3_ez_ff;
         s4_eh_ff <= s3_eh_ff;
         s4_rx_ff <= s3_rx_ff;
         s4_ry_ff <= s3_ry_ff;
         s4_rz_ff <= s3_rz_ff;
         s4_sh_ff <= s3_sh_ff;
         s4_ch_ff <= s3_ch_ff;
      end
   end

   // Stage 5: rotation into the body frame.
   logic signed [U_W+SIN_W:0] rot_x, rot_y;
   logic signed [V_W-1:0] vx_in, vy_in;
   logic signed [V_W-1:0] s5_vx_ff, s5_vy_ff;
   logic signed [U_W-1:0] s5_vz_ff, s5_wz_ff;
   logic signed [POS_W-1:0] s5_ex_ff, s5_ey_ff, s5_ez_ff, s5_eh_ff;
   logic signed [REFP_W-1:0] s5_rx_ff, s5_ry_ff, s5_rz_ff;

   assign rot_x = (U_W + SIN_W + 1)'(s4_ux_ff * s4_ch_ff)
                + (U_W + SIN_W + 1)'(s4_uy_ff * s4_sh_ff) + RND_R;
   assign rot_y = (U_W + SIN_W + 1)'(s4_uy_ff * s4_ch_ff)
                - (U_W + SIN_W + 1)'(s4_ux_ff * s4_sh_ff) + RND_R;
   assign vx_in = V_W'(rot_x >>> FRAC_BITS);
   assign vy_in = V_W'(rot_y >>> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s5_vx_ff <= vx_in;
         s5_vy_ff <= vy_in;
         s5_vz_ff <= s4_vz_ff;
         s5_wz_ff <= s4_wz_ff;
         s5_ex_ff <= s4_ex_ff;
         s5_ey_ff <= s4_ey_ff;
         s5_ez_ff <= s4_ez_ff;
         s5_eh_ff <= s4_eh_ff;
         s5_rx_ff <= s4_rx_ff;
         s5_ry_ff <= s4_ry_ff;
         s5_rz_ff <= s4_rz_ff;
      end
   end

   // Stage 6: saturation into the output register.
   logic signed [V_W-1:0] lxy, lz, lyr;
   logic signed [V_W-1:0] vx_sat, vy_sat, vz_sat, wz_sat;
   logic [FLAG_W-1:0] flags_in;
   logic signed [VEL_W-1:0] o_vx_ff, o_vy_ff, o_vz_ff, o_wz_ff;
   logic [FLAG_W-1:0] o_flags_ff;
   logic signed [POS_W-1:0] o_ex_ff, o_ey_ff, o_ez_ff, o_eh_ff;
   logic signed [POS_W-1:0] o_rx_ff, o_ry_ff, o_rz_ff;

   assign lxy = V_W'($signed({1'b0, cfg.limit_xy}));
   assign lz = V_W'($signed({1'b0, cfg.limit_z}));
   assign lyr = V_W'($signed({1'b0, cfg.limit_yaw_rate}));

   always_comb begin
      flags_in = '0;
      vx_sat = s5_vx_ff;
      vy_sat = s5_vy_ff;
      vz_sat = V_W'(s5_vz_ff);
      wz_sat = V_W'(s5_wz_ff);
      if (vx_sat > lxy) begin
         vx_sat = lxy;
         flags_in[0] = 1'b1;
      end else if (vx_sat < -lxy) begin
         vx_sat = -lxy;
         flags_in[0] = 1'b1;
      end
      if (vy_sat > lxy) begin
         vy_sat = lxy;
         flags_in[1] = 1'b1;
      end else if (vy_sat < -lxy) begin
         vy_sat = -lxy;
         flags_in[1] = 1'b1;
      end
      if (vz_sat > lz) begin
         vz_sat = lz;
         flags_in[2] = 1'b1;
      end else if (vz_sat < -lz) begin
         vz_sat = -lz;
         flags_in[2] = 1'b1;
      end
      if (wz_sat > lyr) begin
         wz_sat = lyr;
         flags_in[3] = 1'b1;
      end else if (wz_sat < -lyr) begin
         wz_sat = -lyr;
         flags_in[3] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         o_vx_ff <= VEL_W'(vx_sat);
         o_vy_ff <= VEL_W'(vy_sat);
         o_vz_ff <= VEL_W'(vz_sat);
         o_wz_ff <= VEL_W'(wz_sat);
         o_flags_ff <= flags_in;
         o_ex_ff <= s5_ex_ff;
         o_ey_ff <= s5_ey_ff;
         o_ez_ff <= s5_ez_ff;
         o_eh_ff <= s5_eh_ff;
         o_rx_ff <= POS_W'(s5_rx_ff);
         o_ry_ff <= POS_W'(s5_ry_ff);
         o_rz_ff <= POS_W'(s5_rz_ff);
      end
   end

   assign rsp.valid = v_ff[NSTG-1];
   assign rsp.vel_x = o_vx_ff;
   assign rsp.vel_y = o_vy_ff;
   assign rsp.vel_z = o_vz_ff;
   assign rsp.yaw_rate = o_wz_ff;
   assign rsp.sat_flags = o_flags_ff;
   assign rsp.err_x = o_ex_ff;
   assign rsp.err_y = o_ey_ff;
   assign rsp.err_z = o_ez_ff;
   assign rsp.err_heading = o_eh_ff;
   assign rsp.ref_x = o_rx_ff;
   assign rsp.ref_y = o_ry_ff;
   assign rsp.ref_z = o_rz_ff;

   logic signed [VEL_W-1:0] chk_lxy, chk_lz;
   assign chk_lxy = VEL_W'($signed({1'b0, cfg.limit_xy}));
   assign chk_lz = VEL_W'($signed({1'b0, cfg.limit_z}));

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> rsp.valid)
      else $error("input stalled while the output register is empty");

   a_flag_x_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.sat_flags[0] |-> (rsp.vel_x == chk_lxy) || (rsp.vel_x == -chk_lxy))
      else $error("forward velocity flagged but not at its limit");

   a_vz_within_limit: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.sat_flags[2] |-> (rsp.vel_z <= chk_lz) && (rsp.vel_z >= -chk_lz))
      else $error("vertical velocity beyond its limit without a flag");

endmodule
